>>> src/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared widths, codes and control types of the Montgomery SOS multiplier.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int MAX_WORDS = 8;
  localparam int WORD_BITS = 32;

  localparam int IDX_W = 3;                        // word_index / out_index field
  localparam int N_W   = $clog2(MAX_WORDS + 1);    // word count 1..MAX_WORDS
  localparam int PB_W  = $clog2(2 * MAX_WORDS);    // product buffer address
  localparam int ACC_W = 2 * WORD_BITS;

  // Input opcodes
  localparam logic OP_MODULUS = 1'b0;
  localparam logic OP_OPERAND = 1'b1;

  // Configuration register indexes
  localparam int  CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_INV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS   = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,     // a*b row by row
    ST_RED_M,   // m = t[i] * n0
    ST_RED,     // t += m*p << i, carry runs to the top
    ST_SUB,     // trial t_hi - p into low half
    ST_OUT
  } state_e;

  typedef struct packed {
    state_e           state;
    logic [IDX_W-1:0] row;
    logic [PB_W-1:0]  col;
    logic             col_last;   // col == n-1
    logic             red_last;   // row + col == 2n-1
    logic             row_last;   // row == n-1
  } ctrl_t;

endpackage

>>> src/mms_mac.sv
// ----------------------------------------------------------------------------
// mms_mac
// Shared word multiply-accumulate: acc = x + y*z + c.
// ----------------------------------------------------------------------------
module mms_mac
  import mms_pkg::*;
(
  input  word_t              x_i,
  input  word_t              y_i,
  input  word_t              z_i,
  input  word_t              c_i,
  output logic [ACC_W-1:0]   acc_o
);

  logic [ACC_W-1:0] prod;

  assign prod  = ACC_W'(y_i) * ACC_W'(z_i);
  // Max (2^w-1)^2 + 2*(2^w-1) = 2^2w - 1, never overflows.
  assign acc_o = prod + ACC_W'(x_i) + ACC_W'(c_i);

endmodule

>>> src/mms_seq.sv
// ----------------------------------------------------------------------------
// mms_seq
// Sequencer: walks multiply, reduce, subtract and output phases.
// ----------------------------------------------------------------------------
module mms_seq
  import mms_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] n_i,
  input  logic           out_ready_i,
  output ctrl_t          ctrl_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic [PB_W-1:0]  col_q, col_d;
  logic [IDX_W-1:0] n_m1;
  logic [PB_W-1:0]  two_n_m1;
  logic [PB_W-1:0]  diag;
  logic             col_last, red_last, row_last;

  assign n_m1     = IDX_W'(n_i - N_W'(1));
  assign two_n_m1 = PB_W'({n_i, 1'b0} - (N_W+1)'(1));
  assign diag     = PB_W'(row_q) + col_q;
  assign col_last = (col_q == PB_W'(n_m1));
  assign red_last = (diag == two_n_m1);
  assign row_last = (row_q == n_m1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_MUL;
      ST_MUL:   if (col_last && row_last) state_d = ST_RED_M;
      ST_RED_M: state_d = ST_RED;
      ST_RED:   if (red_last) state_d = row_last ? ST_SUB : ST_RED_M;
      ST_SUB:   if (row_last) state_d = ST_OUT;
      ST_OUT:   if (out_ready_i && row_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Counters
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (state_q)
      ST_IDLE: begin
        row_d = '0;
        col_d = '0;
      end
      ST_MUL: begin
        if (col_last) begin
          col_d = '0;
          row_d = row_last ? '0 : row_q + IDX_W'(1);
        end else begin
          col_d = col_q + PB_W'(1);
        end
      end
      ST_RED_M: col_d = '0;
      ST_RED: begin
        if (red_last) begin
          col_d = '0;
          row_d = row_last ? '0 : row_q + IDX_W'(1);
        end else begin
          col_d = col_q + PB_W'(1);
        end
      end
      ST_SUB: row_d = row_last ? '0 : row_q + IDX_W'(1);
      ST_OUT: if (out_ready_i) row_d = row_last ? '0 : row_q + IDX_W'(1);
      default: begin
        row_d = '0;
        col_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    ctrl_o.state    = state_q;
    ctrl_o.row      = row_q;
    ctrl_o.col      = col_q;
    ctrl_o.col_last = col_last;
    ctrl_o.red_last = red_last;
    ctrl_o.row_last = row_last;
  end

endmodule

>>> src/montgomery_multiply_sos_unit.sv
// ----------------------------------------------------------------------------
// montgomery_multiply_sos_unit
// Montgomery product a*b*R^-1 mod p, separated operand scanning, 32-bit words.
// ----------------------------------------------------------------------------
// Usage: write the modulus words with opcode 0 beats and set the n0 and word
// count registers while idle. Then send opcode 1 beats, each carrying one word
// of a and b; the beat with word_index = n-1 launches the product, and n result
// beats follow, low word first, tlast on word n-1. The launching beat holds the
// block busy for the work of one 32x32 multiply-accumulate unit, which does
// every step in turn: the a*b rows, then for each reduction row i the m word
// and the row add and carry run, then the trial subtraction and the n output
// beats, which wait while the sink stalls. The stores hold no reset value: a
// product that touches a modulus or operand word never written is undefined.
// The config port is always ready.
// ----------------------------------------------------------------------------
module montgomery_multiply_sos_unit
  import mms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [WORD_BITS-1:0]  cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [71:0]           s_axis_tdata,  // word_index[2:0], first_word, second_word
  input  logic                  s_axis_tuser,  // opcode
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // out_index[2:0], out_word
  output logic                  m_axis_tlast   // out_last
);

  localparam int InIdxLo = 0;
  localparam int InW1Lo  = InIdxLo + IDX_W;
  localparam int InW2Lo  = InW1Lo + WORD_BITS;
  localparam int OutUsed = IDX_W + WORD_BITS;

  // Config registers
  word_t          n0_q;
  logic [N_W-1:0] words_q;
  logic [N_W-1:0] n;

  // Stores and scratch
  word_t mod_q  [MAX_WORDS];
  word_t a_q    [MAX_WORDS];
  word_t b_q    [MAX_WORDS];
  word_t pb_q   [2*MAX_WORDS];
  word_t m_q;
  word_t carry_q;
  logic [3:0] ovf_q;
  logic       use_sub_q;

  logic             in_fire;
  logic             in_opcode;
  logic [IDX_W-1:0] in_idx;
  word_t            in_w1, in_w2;
  logic             idx_ok;
  logic             start;

  ctrl_t            ctrl;
  logic [PB_W-1:0]  diag;
  logic [PB_W-1:0]  hi_addr;
  logic [PB_W-1:0]  top_addr;
  logic [PB_W-1:0]  pb_addr;
  word_t            pb_rd;
  logic             col_in_n;
  word_t            mac_x, mac_y, mac_z, mac_c;
  logic [ACC_W-1:0] acc;
  word_t            acc_lo, acc_hi;

  // ---- config --------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n0_q    <= '0;
      words_q <= N_W'(MAX_WORDS);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MOD_INV: n0_q    <= cfg_data_i;
        CFG_WORDS:   words_q <= cfg_data_i[N_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the store depth as the full depth
  always_comb begin
    n = words_q;
    if (words_q == '0) n = N_W'(1);
    else if ((N_W+1)'(words_q) > (N_W+1)'(MAX_WORDS)) n = N_W'(MAX_WORDS);
  end

  // ---- input side ----------------------------------------------------------
  assign in_opcode     = s_axis_tuser;
  assign in_idx        = s_axis_tdata[InIdxLo +: IDX_W];
  assign in_w1         = s_axis_tdata[InW1Lo +: WORD_BITS];
  assign in_w2         = s_axis_tdata[InW2Lo +: WORD_BITS];
  assign s_axis_tready = (ctrl.state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = (32'(in_idx) < MAX_WORDS);
  assign start         = in_fire && idx_ok && (in_opcode == OP_OPERAND) &&
                         (N_W'(in_idx) == n - N_W'(1));

  always_ff @(posedge clk_i) begin
    if (in_fire && idx_ok) begin
      if (in_opcode == OP_MODULUS) begin
        mod_q[in_idx] <= in_w1;
      end else begin
        a_q[in_idx] <= in_w1;
        b_q[in_idx] <= in_w2;
      end
    end
  end

  // ---- sequencer -----------------------------------------------------------
  mms_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .n_i         (n),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  // ---- product buffer addressing -------------------------------------------
  assign diag     = PB_W'(ctrl.row) + ctrl.col;
  assign hi_addr  = PB_W'(n) + PB_W'(ctrl.row);
  assign col_in_n = ((N_W+PB_W)'(ctrl.col) < (N_W+PB_W)'(n));

  always_comb begin
    case (ctrl.state)
      ST_MUL, ST_RED: pb_addr = diag;
      ST_RED_M:       pb_addr = PB_W'(ctrl.row);
      ST_SUB:         pb_addr = hi_addr;
      ST_OUT:         pb_addr = use_sub_q ? PB_W'(ctrl.row) : hi_addr;
      default:        pb_addr = '0;
    endcase
  end

  assign pb_rd = pb_q[pb_addr];

  // ---- shared MAC operand select ------------------------------------------
  always_comb begin
    mac_x = '0;
    mac_y = '0;
    mac_z = '0;
    mac_c = '0;
    case (ctrl.state)
      ST_MUL: begin
        // row 0 starts from an empty accumulator
        mac_x = (ctrl.row == '0) ? '0 : pb_rd;
        mac_y = a_q[ctrl.row];
        mac_z = b_q[ctrl.col[IDX_W-1:0]];
        mac_c = (ctrl.col == '0) ? '0 : carry_q;
      end
      ST_RED_M: begin
        mac_y = pb_rd;
        mac_z = n0_q;
      end
      ST_RED: begin
        // past column n-1 only the carry runs on
        mac_x = pb_rd;
        mac_y = col_in_n ? m_q : '0;
        mac_z = mod_q[ctrl.col[IDX_W-1:0]];
        mac_c = (ctrl.col == '0) ? '0 : carry_q;
      end
      ST_SUB: begin
        // x - p - borrow as x + ~p + !borrow; carry_q holds !borrow
        mac_x = pb_rd;
        mac_y = ~mod_q[ctrl.row];
        mac_z = word_t'(1);
        mac_c = (ctrl.row == '0) ? word_t'(1) : carry_q;
      end
      default: ;
    endcase
  end

  mms_mac u_mac (
    .x_i   (mac_x),
    .y_i   (mac_y),
    .z_i   (mac_z),
    .c_i   (mac_c),
    .acc_o (acc)
  );

  assign acc_lo   = acc[WORD_BITS-1:0];
  assign acc_hi   = acc[ACC_W-1:WORD_BITS];
  assign top_addr = PB_W'(ctrl.row) + PB_W'(n);

  // ---- datapath registers --------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (ctrl.state)
      ST_MUL: begin
        pb_q[diag] <= acc_lo;
        if (ctrl.col_last) pb_q[top_addr] <= acc_hi;
        carry_q <= acc_hi;
      end
      ST_RED_M: m_q <= acc_lo;
      ST_RED: begin
        pb_q[diag] <= acc_lo;
        carry_q    <= acc_hi;
      end
      ST_SUB: begin
        // difference lands in the free low half
        pb_q[PB_W'(ctrl.row)] <= acc_lo;
        carry_q               <= acc_hi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q     <= '0;
      use_sub_q <= 1'b0;
    end else begin
      if (start) begin
        ovf_q <= '0;
      end else if (ctrl.state == ST_RED && ctrl.red_last && acc[WORD_BITS] &&
                   ovf_q != '1) begin
        ovf_q <= ovf_q + 4'd1;
      end
      // subtract on reduction overflow or when no borrow (t_hi >= p)
      if (ctrl.state == ST_SUB && ctrl.row_last) begin
        use_sub_q <= (ovf_q != '0) || acc[WORD_BITS];
      end
    end
  end

  // ---- result side ---------------------------------------------------------
  assign m_axis_tvalid = (ctrl.state == ST_OUT);
  assign m_axis_tdata  = {(40 - OutUsed)'(0), pb_rd, ctrl.row};
  assign m_axis_tlast  = ctrl.row_last;

endmodule
